// ----- rtl/cma_pkg.sv -----
// shared widths, types and reset constants of the centered moving average
`timescale 1ns / 1ps
`default_nettype none
package cma_pkg;
   localparam int VALUE_W         = 32;
   localparam int WINDOW_W        = 7;
   localparam int SUM_W           = 40;
   localparam int SEEN_W          = 8;
   localparam int DEF_MAX_WINDOW  = 64;
   localparam int DEF_RING_DEPTH  = 128;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [WINDOW_W-1:0]       window_type;

   localparam window_type WINDOW_RESET = window_type'(5);
endpackage
`default_nettype wire

// ----- rtl/cma_if.sv -----
// valid/ready channel interfaces for samples, results and the window register
`timescale 1ns / 1ps
`default_nettype none
interface cma_req_if
   import cma_pkg::*;
   ();
   logic      valid;
   logic      ready;
   value_type sample_value;
   value_type temperature;
   value_type timestamp;
   logic      last_in;
   modport source (output valid, sample_value, temperature, timestamp, last_in, input ready);
   modport sink   (input valid, sample_value, temperature, timestamp, last_in, output ready);
endinterface

interface cma_rsp_if
   import cma_pkg::*;
   ();
   logic      valid;
   logic      ready;
   value_type filtered_value;
   value_type temperature_out;
   value_type timestamp_out;
   logic      last_out;
   modport source (output valid, filtered_value, temperature_out, timestamp_out, last_out,
                   input ready);
   modport sink   (input valid, filtered_value, temperature_out, timestamp_out, last_out,
                   output ready);
endinterface

interface cma_csr_if
   import cma_pkg::*;
   ();
   logic       valid;
   logic       ready;
   window_type window;
   modport source (output valid, window, input ready);
   modport sink   (input valid, window, output ready);
endinterface
`default_nettype wire

// ----- rtl/centered_moving_average.sv -----
// centered moving average over a sample ring with a shared adder and serial divider
// sequence: a word that completes a window goes through setup, ring reads and accumulation
//   of cnt = points in the window (up to 2*half+1), then the 40-step divider and the output state
// throughput: one word in flight, no new sample is taken until its result is accepted; the last
//   word flushes up to half+1 results one after another through the same add/divide loop
// reset: synchronous active high, window returns to 5, stream counters clear
`timescale 1ns / 1ps
`default_nettype none
module centered_moving_average
   import cma_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int RING_DEPTH = DEF_RING_DEPTH
) (
   input  wire        clock,
   input  wire        reset,
   cma_req_if.sink    req_ch,
   cma_rsp_if.source  rsp_ch,
   cma_csr_if.sink    csr_ch
);
   localparam int AW       = $clog2(RING_DEPTH);
   localparam int IX_W     = AW + 1;
   localparam int PEND_W   = $clog2(MAX_WINDOW / 2 + 2);
   localparam int CNT_W    = $clog2(MAX_WINDOW + 2);
   localparam int DCNT_W   = $clog2(SUM_W + 1);
   localparam int HALF_CAP = (RING_DEPTH - 1) / 2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_ACCUM, ST_DIVIDE, ST_OUTPUT
   } state_type;

   state_type          state_ff;
   window_type         window_ff;
   logic [PEND_W-1:0]  half_ff;
   logic [PEND_W-1:0]  pend_ff;
   logic [SEEN_W-1:0]  seen_ff;
   logic [AW-1:0]      wr_pos_ff;
   logic               last_ff;

   // ring memories, values read in sequence, pass-through fields at the center
   value_type          value_ring [RING_DEPTH];
   value_type          temperature_ring [RING_DEPTH];
   value_type          time_ring [RING_DEPTH];
   logic [AW-1:0]      rd_addr_ff;
   logic [AW-1:0]      center_ff;
   value_type          value_q_ff;
   value_type          temp_q_ff;
   value_type          time_q_ff;
   logic               rd_vld_ff;

   // accumulate and divide
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   issue_left_ff;
   logic [CNT_W-1:0]   add_left_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0]   quot_ff;
   logic [CNT_W-1:0]   rem_ff;
   logic [DCNT_W-1:0]  div_cnt_ff;
   logic               neg_ff;

   // result word
   value_type          filtered_ff;
   value_type          temp_out_ff;
   value_type          time_out_ff;
   logic               last_out_ff;

   // window register to half width, clamped to the legal range
   window_type         win_clamped;
   logic [WINDOW_W-1:0] half_raw;
   logic [PEND_W-1:0]  half_cfg;

   always_comb begin
      if (window_ff == '0) begin
         win_clamped = window_type'(1);
      end else if (window_ff > window_type'(MAX_WINDOW)) begin
         win_clamped = window_type'(MAX_WINDOW);
      end else begin
         win_clamped = window_ff;
      end
      half_raw = win_clamped >> 1;
      if (half_raw > WINDOW_W'(HALF_CAP)) begin
         half_cfg = PEND_W'(HALF_CAP);
      end else begin
         half_cfg = PEND_W'(half_raw);
      end
   end

   // accept-time bookkeeping, a new stream restarts the ring
   logic               req_fire;
   logic               new_stream;
   logic [AW-1:0]      wp;
   logic [PEND_W-1:0]  pend_in;
   logic [PEND_W-1:0]  half_in;
   logic [AW-1:0]      wr_pos_in;
   logic [SEEN_W-1:0]  seen_in;

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign new_stream = (seen_ff == '0);
   assign wp         = new_stream ? '0 : wr_pos_ff;
   assign pend_in    = (new_stream ? '0 : pend_ff) + PEND_W'(1);
   assign half_in    = new_stream ? half_cfg : half_ff;
   assign wr_pos_in  = (wp == AW'(RING_DEPTH - 1)) ? '0 : wp + AW'(1);
   assign seen_in    = (seen_ff == '1) ? seen_ff : seen_ff + SEEN_W'(1);

   // window geometry of the oldest pending point
   logic [SEEN_W-1:0]  seen_minus_pend;
   logic [PEND_W-1:0]  left;
   logic [PEND_W-1:0]  right;
   logic [IX_W-1:0]    c_wide;
   logic [IX_W-1:0]    p_wide;
   logic [AW-1:0]      c_idx;
   logic [AW-1:0]      p_idx;

   always_comb begin
      seen_minus_pend = seen_ff - SEEN_W'(pend_ff);
      if (seen_minus_pend > SEEN_W'(half_ff)) begin
         left = half_ff;
      end else begin
         left = PEND_W'(seen_minus_pend);
      end
      if ((pend_ff - PEND_W'(1)) > half_ff) begin
         right = half_ff;
      end else begin
         right = pend_ff - PEND_W'(1);
      end
      if (IX_W'(wr_pos_ff) >= IX_W'(pend_ff)) begin
         c_wide = IX_W'(wr_pos_ff) - IX_W'(pend_ff);
      end else begin
         c_wide = IX_W'(wr_pos_ff) + IX_W'(RING_DEPTH) - IX_W'(pend_ff);
      end
      if (c_wide >= IX_W'(left)) begin
         p_wide = c_wide - IX_W'(left);
      end else begin
         p_wide = c_wide + IX_W'(RING_DEPTH) - IX_W'(left);
      end
      c_idx = c_wide[AW-1:0];
      p_idx = p_wide[AW-1:0];
   end

   // one restoring divide step on the magnitude of the sum
   logic [CNT_W:0]     rem_sh;
   logic               q_bit;
   logic [CNT_W-1:0]   rem_next;
   logic [SUM_W-1:0]   quot_next;
   logic [SUM_W-1:0]   sum_mag;
   value_type          q_low;

   always_comb begin
      rem_sh    = {rem_ff, quot_ff[SUM_W-1]};
      q_bit     = (rem_sh >= {1'b0, cnt_ff});
      rem_next  = q_bit ? CNT_W'(rem_sh - {1'b0, cnt_ff}) : rem_sh[CNT_W-1:0];
      quot_next = {quot_ff[SUM_W-2:0], q_bit};
      sum_mag   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      q_low     = neg_ff ? value_type'(-quot_next[VALUE_W-1:0])
                         : value_type'(quot_next[VALUE_W-1:0]);
   end

   assign req_ch.ready           = (state_ff == ST_IDLE);
   assign csr_ch.ready           = 1'b1;
   assign rsp_ch.valid           = (state_ff == ST_OUTPUT);
   assign rsp_ch.filtered_value  = filtered_ff;
   assign rsp_ch.temperature_out = temp_out_ff;
   assign rsp_ch.timestamp_out   = time_out_ff;
   assign rsp_ch.last_out        = last_out_ff;

   // ring writes on accept, registered reads every cycle
   always_ff @(posedge clock) begin
      if (req_fire) begin
         value_ring[wp]       <= req_ch.sample_value;
         temperature_ring[wp] <= req_ch.temperature;
         time_ring[wp]        <= req_ch.timestamp;
      end
      value_q_ff <= value_ring[rd_addr_ff];
      temp_q_ff  <= temperature_ring[center_ff];
      time_q_ff  <= time_ring[center_ff];
   end

   // sequencer: accept, set up window, accumulate, divide, present word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         window_ff <= WINDOW_RESET;
         half_ff   <= '0;
         pend_ff   <= '0;
         seen_ff   <= '0;
         wr_pos_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            window_ff <= csr_ch.window;
         end
         rd_vld_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  half_ff   <= half_in;
                  pend_ff   <= pend_in;
                  seen_ff   <= seen_in;
                  wr_pos_ff <= wr_pos_in;
                  last_ff   <= req_ch.last_in;
                  if (req_ch.last_in || (pend_in > half_in)) begin
                     state_ff <= ST_SETUP;
                  end
               end
            end
            ST_SETUP: begin
               center_ff     <= c_idx;
               rd_addr_ff    <= p_idx;
               cnt_ff        <= CNT_W'(left) + CNT_W'(right) + CNT_W'(1);
               issue_left_ff <= CNT_W'(left) + CNT_W'(right) + CNT_W'(1);
               add_left_ff   <= CNT_W'(left) + CNT_W'(right) + CNT_W'(1);
               sum_ff        <= '0;
               state_ff      <= ST_ACCUM;
            end
            ST_ACCUM: begin
               if (issue_left_ff != '0) begin
                  rd_vld_ff     <= 1'b1;
                  issue_left_ff <= issue_left_ff - CNT_W'(1);
                  rd_addr_ff    <= (rd_addr_ff == AW'(RING_DEPTH - 1)) ? '0
                                                                       : rd_addr_ff + AW'(1);
               end
               if (rd_vld_ff) begin
                  sum_ff      <= sum_ff + {{(SUM_W - VALUE_W){value_q_ff[VALUE_W-1]}},
                                           value_q_ff};
                  add_left_ff <= add_left_ff - CNT_W'(1);
                  if (add_left_ff == CNT_W'(1)) begin
                     state_ff <= ST_DIVIDE;
                  end
               end
               // divider counter and remainder clear here; the magnitude loads on the first divide cycle
               div_cnt_ff <= DCNT_W'(SUM_W);
               rem_ff     <= '0;
               quot_ff    <= '0;
               neg_ff     <= 1'b0;
            end
            ST_DIVIDE: begin
               if (div_cnt_ff == DCNT_W'(SUM_W)) begin
                  // load the magnitude once, then shift
                  quot_ff    <= sum_mag;
                  neg_ff     <= sum_ff[SUM_W-1];
                  div_cnt_ff <= DCNT_W'(SUM_W - 1);
               end else begin
                  quot_ff    <= quot_next;
                  rem_ff     <= rem_next;
                  div_cnt_ff <= div_cnt_ff - DCNT_W'(1);
                  if (div_cnt_ff == '0) begin
                     filtered_ff <= q_low;
                     temp_out_ff <= temp_q_ff;
                     time_out_ff <= time_q_ff;
                     last_out_ff <= last_ff && (pend_ff == PEND_W'(1));
                     state_ff    <= ST_OUTPUT;
                  end
               end
            end
            ST_OUTPUT: begin
               if (rsp_ch.ready) begin
                  pend_ff <= pend_ff - PEND_W'(1);
                  if (!last_ff) begin
                     state_ff <= ST_IDLE;
                  end else if (pend_ff == PEND_W'(1)) begin
                     seen_ff   <= '0;
                     wr_pos_ff <= '0;
                     state_ff  <= ST_IDLE;
                  end else begin
                     state_ff <= ST_SETUP;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- tb/centered_moving_average_tb.sv -----
// self-checking testbench for the centered moving average: window-mean predictor and stimulus
`timescale 1ns / 1ps
module centered_moving_average_tb;
   import cma_pkg::*;

   localparam int CLK_PERIOD    = 12;
   localparam int RESET_CYCLES  = 12;
   localparam int MAX_WIN       = DEF_MAX_WINDOW;
   localparam int RING          = DEF_RING_DEPTH;
   localparam int SEEN_MAX      = (1 << SEEN_W) - 1;
   localparam int WINDOW_TOP    = (1 << WINDOW_W) - 1;
   // a window of 65 points plus the 40-step divider, with margin
   localparam int SETTLE_CYCLES = 160;
   localparam int HOLD_CYCLES   = 500;
   localparam int RANDOM_ITEMS  = 160;
   localparam int LONG_STREAM   = 130;
   localparam int LONG_SLOT     = 4;
   localparam int CYCLE_LIMIT   = 500_000;
   localparam int REPORT_LIMIT  = 10;

   localparam value_type VMAX = 32'sh7fff_ffff;
   localparam value_type VMIN = 32'sh8000_0000;

   typedef struct packed {
      value_type mean;
      value_type temperature;
      value_type stamp;
      logic      last;
   } smoothed_type;

   // keeps its own copy of the sample history and the window register,
   // predicts the smoothed words and checks them in order
   class smoothing_board_type;
      value_type    value_hist[RING];
      value_type    temp_hist[RING];
      value_type    stamp_hist[RING];
      int unsigned  points_seen;
      int unsigned  points_waiting;
      int unsigned  write_slot;
      int unsigned  half_width;
      window_type   window_reg;
      smoothed_type smoothed_queue[$];
      int unsigned  failures;

      function new();
         window_reg     = WINDOW_RESET;
         points_seen    = 0;
         points_waiting = 0;
         write_slot     = 0;
         half_width     = 0;
         failures       = 0;
      endfunction

      function void set_window(window_type w);
         window_reg = w;
      endfunction

      function int unsigned half_of(window_type w);
         int unsigned span;
         span = w;
         if (span < 1) span = 1;
         if (span > MAX_WIN) span = MAX_WIN;
         span = span / 2;
         return (span > (RING - 1) / 2) ? (RING - 1) / 2 : span;
      endfunction

      // oldest waiting point becomes the center of the window
      function void emit_centered(logic last);
         int unsigned center, left, right, count, slot;
         logic signed [SUM_W-1:0] total, divisor;
         smoothed_type entry;
         center = (write_slot + RING - points_waiting) % RING;
         left   = points_seen - points_waiting;
         if (left > half_width) left = half_width;
         right  = points_waiting - 1;
         if (right > half_width) right = half_width;
         count  = left + 1 + right;
         slot   = (center + RING - left) % RING;
         total  = '0;
         for (int i = 0; i < count; i++) begin
            total = total + value_hist[slot];
            slot  = (slot + 1) % RING;
         end
         divisor           = count;
         entry.mean        = value_type'(total / divisor);
         entry.temperature = temp_hist[center];
         entry.stamp       = stamp_hist[center];
         entry.last        = last;
         smoothed_queue.push_back(entry);
         points_waiting--;
      endfunction

      function void take_sample(value_type v, value_type temp, value_type stamp, logic last);
         if (points_seen == 0) begin
            half_width     = half_of(window_reg);
            write_slot     = 0;
            points_waiting = 0;
         end
         value_hist[write_slot] = v;
         temp_hist[write_slot]  = temp;
         stamp_hist[write_slot] = stamp;
         write_slot = (write_slot + 1) % RING;
         if (points_seen < SEEN_MAX) points_seen++;
         points_waiting++;
         if (!last) begin
            if (points_waiting > half_width) emit_centered(1'b0);
         end else begin
            while (points_waiting > 0) emit_centered(points_waiting == 1);
            points_seen    = 0;
            points_waiting = 0;
            write_slot     = 0;
         end
      endfunction

      function void check_smoothed(smoothed_type got);
         smoothed_type want;
         if (smoothed_queue.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected word: mean %0d temp %h time %h last %b",
                        got.mean, got.temperature, got.stamp, got.last);
            return;
         end
         want = smoothed_queue.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("mismatch: expected mean %0d temp %h time %h last %b",
                        want.mean, want.temperature, want.stamp, want.last);
               $display("          got      mean %0d temp %h time %h last %b",
                        got.mean, got.temperature, got.stamp, got.last);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   cma_req_if req_ch ();
   cma_rsp_if rsp_ch ();
   cma_csr_if csr_ch ();

   smoothing_board_type board = new();

   // sender skips its gaps while set
   bit sender_steady = 1'b0;
   // sender asks the reader for one long hold-off
   bit hold_request  = 1'b0;

   centered_moving_average DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- helpers

   function automatic value_type pick_value();
      case ($urandom_range(0, 3))
         0: return value_type'($signed($urandom_range(0, 2097152)) - 1048576);
         1: begin
            case ($urandom_range(0, 3))
               0: return VMAX;
               1: return VMIN;
               2: return '0;
               default: return -1;
            endcase
         end
         default: return value_type'($urandom);
      endcase
   endfunction

   // mostly short windows, now and then zero, the top and beyond the top
   function automatic window_type pick_window();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return window_type'($urandom_range(MAX_WIN + 1, WINDOW_TOP));
         2: return window_type'(MAX_WIN);
         3: return window_type'($urandom_range(10, MAX_WIN - 1));
         default: return window_type'($urandom_range(1, 9));
      endcase
   endfunction

   // offer one sample word; valid stays high into the next word when there is no gap
   task automatic send_point(input value_type v, input value_type temp,
                             input value_type stamp, input logic last);
      int unsigned gap;
      gap = sender_steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.sample_value <= v;
      req_ch.temperature  <= temp;
      req_ch.timestamp    <= stamp;
      req_ch.last_in      <= last;
      do @(posedge clock); while (!req_ch.ready);
      board.take_sample(v, temp, stamp, last);
   endtask

   task automatic send_stream(input int unsigned length);
      for (int unsigned i = 0; i < length; i++)
         send_point(pick_value(), value_type'($urandom), value_type'($urandom),
                    i == length - 1);
   endtask

   // window register write, only while the block is idle
   task automatic write_window(input window_type w);
      csr_ch.valid  <= 1'b1;
      csr_ch.window <= w;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid  <= 1'b0;
      board.set_window(w);
   endtask

   // stop offering, wait for every predicted word, then let the divider settle
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (board.smoothed_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- result side

   initial begin : result_reader
      int unsigned  stall_left;
      int unsigned  taken;
      bit           steady;
      smoothed_type got;
      stall_left = 0;
      taken      = 0;
      steady     = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.filtered_value, rsp_ch.temperature_out,
                    rsp_ch.timestamp_out, rsp_ch.last_out};
            board.check_smoothed(got);
            taken++;
            // every twenty words decide whether the next stretch runs without stalls
            if (taken % 20 == 0) steady = ($urandom_range(0, 3) == 0);
            stall_left = steady ? 0 : $urandom_range(0, 19);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         // long hold-off so the block fills up and pushes back on the sender
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
         end
         rsp_ch.ready <= !reset && (stall_left == 0);
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      int unsigned sent;
      int unsigned stream_no;
      int unsigned length;

      // known values on every input from the first step
      req_ch.valid        <= 1'b0;
      req_ch.sample_value <= '0;
      req_ch.temperature  <= '0;
      req_ch.timestamp    <= '0;
      req_ch.last_in      <= 1'b0;
      csr_ch.valid        <= 1'b0;
      csr_ch.window       <= WINDOW_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset window of five, extreme values and signs, truncation toward zero
      send_point(VMAX, VMIN, VMAX, 1'b0);
      send_point(VMIN, VMAX, VMIN, 1'b0);
      send_point('0, '0, '0, 1'b0);
      send_point(-1, -1, 32'sh5555_5555, 1'b0);
      send_point(1, 32'sh2aaa_aaaa, 32'sh1, 1'b1);

      // window zero behaves as one
      drain_results();
      write_window('0);
      send_stream(3);

      // window one with a single-word stream
      drain_results();
      write_window(window_type'(1));
      send_stream(1);

      // even window widens to the next odd one
      drain_results();
      write_window(window_type'(2));
      send_stream(3);

      // largest register value saturates, stream shorter than the half width
      drain_results();
      write_window(window_type'(WINDOW_TOP));
      send_stream(4);

      // top of the legal range
      drain_results();
      write_window(window_type'(MAX_WIN));
      send_stream(2);

      // window changed mid-stream: the half width latched at the first word holds
      drain_results();
      write_window(window_type'(3));
      send_point(pick_value(), value_type'($urandom), value_type'($urandom), 1'b0);
      send_point(pick_value(), value_type'($urandom), value_type'($urandom), 1'b0);
      drain_results();
      write_window(window_type'(9));
      send_point(pick_value(), value_type'($urandom), value_type'($urandom), 1'b0);
      send_point(pick_value(), value_type'($urandom), value_type'($urandom), 1'b1);

      // random streams; one long one wraps the ring while the reader holds off
      sent      = 0;
      stream_no = 0;
      while (sent < RANDOM_ITEMS) begin
         if (stream_no == LONG_SLOT) begin
            drain_results();
            write_window(window_type'(3));
            sender_steady = 1'b0;
            hold_request  = 1'b1;
            length        = LONG_STREAM;
         end else begin
            // about half the streams start after a full drain with a new window
            if ($urandom_range(0, 1) == 0) begin
               drain_results();
               write_window(pick_window());
            end
            sender_steady = ($urandom_range(0, 3) == 0);
            length        = $urandom_range(1, 10);
         end
         send_stream(length);
         sent += length;
         stream_no++;
      end

      drain_results();
      if (board.failures == 0 && board.smoothed_queue.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/cma_pkg.sv
rtl/cma_if.sv
rtl/centered_moving_average.sv
tb/centered_moving_average_tb.sv
